// File: rtl/core/integer_to_ascii_formatter_unit_defines.svh
// Assertion macros shared by the formatter RTL.
// Included by the top level only; no other dependencies.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITAF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITAF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/itaf_pkg.sv
// Shared types, constants and helper functions for the integer formatter.
// No dependencies; used by itaf_ctrl, itaf_dpath and the top level.
package itaf_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_RUN    = 64;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_STEP_BITS = 8;

    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 36;
    localparam int DIGIT_SET = 36;
    localparam int PFX_X_IDX = 33;
    localparam int RADIX_OCT = 8;
    localparam int RADIX_HEX = 16;

    localparam int FLG_ZEROPAD = 0;
    localparam int FLG_SIGNED  = 1;
    localparam int FLG_PLUS    = 2;
    localparam int FLG_SPACE   = 3;
    localparam int FLG_LEFT    = 4;
    localparam int FLG_PREFIX  = 5;
    localparam int FLG_UPPER   = 6;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    localparam int SEG_NUM = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_SEL,
        ST_EMIT
    } itaf_state_t;

    // Output segments in emission order.
    typedef enum logic [2:0] {
        SEG_LEAD  = 3'd0,
        SEG_SIGN  = 3'd1,
        SEG_PFX   = 3'd2,
        SEG_FILL  = 3'd3,
        SEG_PZERO = 3'd4,
        SEG_DIGIT = 3'd5,
        SEG_TRAIL = 3'd6
    } itaf_seg_t;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      prep;
        logic      seg_load;
        itaf_seg_t seg_sel;
        itaf_seg_t emit_seg;
        logic      emit;
        logic      last;
    } itaf_cmd_t;

    typedef struct packed {
        logic               radix_ok;
        logic               div_last;
        logic               quo_zero;
        logic [SEG_NUM-1:0] seg_nz;
        logic               cnt_one;
        logic               run_cap;
        logic               out_free;
    } itaf_stat_t;

    typedef struct packed {
        logic      found;
        itaf_seg_t seg;
    } itaf_pick_t;

    // Lowest nonempty segment at or after 'from'.
    function automatic itaf_pick_t seg_pick(input logic [SEG_NUM-1:0] nz,
                                            input logic [3:0] from);
        itaf_pick_t p;
        p.found = 1'b0;
        p.seg   = SEG_LEAD;
        for (int i = SEG_NUM - 1; i >= 0; i--) begin
            if ((4'(i) >= from) && nz[i]) begin
                p.found = 1'b1;
                p.seg   = itaf_seg_t'(3'(i));
            end
        end
        return p;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [5:0] v;
        v = (d >= 6'(DIGIT_SET)) ? d - 6'(DIGIT_SET) : d;
        if (v < 6'd10) begin
            return CH_ZERO + 8'(v);
        end
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 6'd10);
    endfunction

endpackage

// File: rtl/core/itaf_ctrl.sv
// Controller state machine: sequences division, segment setup and emission.
// Depends on itaf_pkg; drives itaf_dpath through itaf_cmd_t.
module itaf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  itaf_pkg::itaf_stat_t st,
    output itaf_pkg::itaf_cmd_t  cmd
);
    import itaf_pkg::*;

    itaf_state_t state_reg, state_next;
    itaf_seg_t   seg_reg, seg_next;
    itaf_pick_t  pick_first, pick_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= SEG_LEAD;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

    assign pick_first = seg_pick(st.seg_nz, 4'd0);
    assign pick_next  = seg_pick(st.seg_nz, {1'b0, seg_reg} + 4'd1);

    always_comb
    begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        cmd          = '0;
        cmd.emit_seg = seg_reg;
        in_stall     = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid && st.radix_ok)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last && st.quo_zero)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                // digit segment is never empty, so a segment is always found
                cmd.seg_load = 1'b1;
                cmd.seg_sel  = pick_first.seg;
                seg_next     = pick_first.seg;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (st.cnt_one && !pick_next.found) || st.run_cap;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (st.cnt_one)
                    begin
                        cmd.seg_load = 1'b1;
                        cmd.seg_sel  = pick_next.seg;
                        seg_next     = pick_next.seg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/itaf_dpath.sv
// Datapath: sign handling, radix divider, digit store, segment counters
// and the output register. Depends on itaf_pkg; controlled by itaf_ctrl.
module itaf_dpath #(
    parameter int VALUE_BITS = itaf_pkg::DEF_VALUE_BITS,
    parameter int MAX_RUN    = itaf_pkg::DEF_MAX_RUN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [5:0]            radix,
    input  logic [6:0]            total_width,
    input  logic [5:0]            min_digits,
    input  logic [6:0]            format_flags,
    input  itaf_pkg::itaf_cmd_t   cmd,
    output itaf_pkg::itaf_stat_t  st,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_char,
    output logic                  last_char
);
    import itaf_pkg::*;

    localparam int DIV_W   = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS)
                             * DIV_STEP_BITS;
    localparam int DIV_CYC = DIV_W / DIV_STEP_BITS;
    localparam int STEP_W  = $clog2(DIV_CYC + 1);
    localparam int AW      = $clog2(VALUE_BITS);
    localparam int DCNT_W  = $clog2(VALUE_BITS + 1);
    localparam int CNT_W   = $clog2(((MAX_RUN > VALUE_BITS) ? MAX_RUN : VALUE_BITS) + 1);
    localparam int SZ_W    = CNT_W + 2;

    // input decode
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic                  left_in;

    // divider
    logic [DIV_W-1:0]  q_reg;
    logic [5:0]        rem_reg;
    logic [5:0]        radix_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_W-1:0]  div_q;
    logic [6:0]        div_r;
    logic              div_last;

    // digit store
    logic [5:0]        store [0:VALUE_BITS-1];
    logic [DCNT_W-1:0] dcnt_reg;
    logic [5:0]        rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [CNT_W-1:0]  cnt_dec;

    // formatting attributes
    logic             has_sign_reg;
    logic [7:0]       sign_ch_reg;
    logic [1:0]       pfx_len_reg;
    logic             left_reg;
    logic             zp_reg;
    logic             upper_reg;
    logic [CNT_W-1:0] fw_reg;
    logic [CNT_W-1:0] prec_reg;

    // segment sequencing
    logic [CNT_W-1:0]        n_dig;
    logic [CNT_W-1:0]        precp;
    logic [SZ_W-1:0]         size_s;
    logic [CNT_W-1:0]        pad;
    logic [CNT_W-1:0]        seg_len_reg [0:SEG_NUM-1];
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        run_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       last_reg;
    logic [7:0] emit_ch;

    assign neg     = format_flags[FLG_SIGNED] && value[VALUE_BITS-1];
    assign mag     = neg ? (~value + 1'b1) : value;
    assign left_in = format_flags[FLG_LEFT];

    // DIV_STEP_BITS restoring steps per cycle on a narrow remainder
    always_comb
    begin
        div_r = {1'b0, rem_reg};
        div_q = q_reg;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            div_r = {div_r[5:0], div_q[DIV_W-1]};
            div_q = {div_q[DIV_W-2:0], 1'b0};
            if (div_r >= {1'b0, radix_reg})
            begin
                div_r    = div_r - {1'b0, radix_reg};
                div_q[0] = 1'b1;
            end
        end
    end

    assign div_last = (step_reg == STEP_W'(DIV_CYC - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= div_last ? '0 : step_reg + 1'b1;
            if (div_last)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg        <= DIV_W'(mag);
            rem_reg      <= '0;
            radix_reg    <= radix;
            left_reg     <= left_in;
            zp_reg       <= format_flags[FLG_ZEROPAD] && !left_in;
            upper_reg    <= format_flags[FLG_UPPER];
            has_sign_reg <= format_flags[FLG_SIGNED] && (neg || format_flags[FLG_PLUS]
                                                         || format_flags[FLG_SPACE]);
            sign_ch_reg  <= neg ? CH_MINUS : (format_flags[FLG_PLUS] ? CH_PLUS : CH_SPACE);
            if (!format_flags[FLG_PREFIX])
            begin
                pfx_len_reg <= 2'd0;
            end
            else if (radix == 6'(RADIX_HEX))
            begin
                pfx_len_reg <= 2'd2;
            end
            else if (radix == 6'(RADIX_OCT))
            begin
                pfx_len_reg <= 2'd1;
            end
            else
            begin
                pfx_len_reg <= 2'd0;
            end
            fw_reg   <= (total_width > 7'(MAX_RUN)) ? CNT_W'(MAX_RUN) : CNT_W'(total_width);
            prec_reg <= (min_digits > 6'(MAX_RUN - 3)) ? CNT_W'(MAX_RUN - 3)
                                                       : CNT_W'(min_digits);
        end
        else if (cmd.div_step)
        begin
            q_reg   <= div_q;
            // restart the remainder for the next digit
            rem_reg <= div_last ? 6'd0 : div_r[5:0];
        end
    end

    // digit store: write one digit per divide, read registered
    assign cnt_dec = cnt_next - 1'b1;
    assign rd_addr = cnt_dec[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && div_last)
        begin
            store[dcnt_reg[AW-1:0]] <= div_r[5:0];
        end
        rd_data_reg <= store[rd_addr];
    end

    // segment lengths
    assign n_dig  = CNT_W'(dcnt_reg);
    assign precp  = (prec_reg > n_dig) ? prec_reg : n_dig;
    assign size_s = SZ_W'(fw_reg) - SZ_W'(has_sign_reg) - SZ_W'(pfx_len_reg) - SZ_W'(precp);
    assign pad    = (!size_s[SZ_W-1] && (size_s != '0)) ? size_s[CNT_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            seg_len_reg[SEG_LEAD]  <= (!zp_reg && !left_reg) ? pad : '0;
            seg_len_reg[SEG_SIGN]  <= CNT_W'(has_sign_reg);
            seg_len_reg[SEG_PFX]   <= CNT_W'(pfx_len_reg);
            seg_len_reg[SEG_FILL]  <= zp_reg ? pad : '0;
            seg_len_reg[SEG_PZERO] <= precp - n_dig;
            seg_len_reg[SEG_DIGIT] <= n_dig;
            seg_len_reg[SEG_TRAIL] <= left_reg ? pad : '0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.seg_load)
        begin
            cnt_next = seg_len_reg[cmd.seg_sel];
        end
        else if (cmd.emit)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.prep)
            begin
                run_reg <= '0;
            end
            else if (cmd.emit)
            begin
                run_reg <= run_reg + 1'b1;
            end
        end
    end

    // character for the current segment
    always_comb
    begin
        case (cmd.emit_seg)
            SEG_SIGN:  emit_ch = sign_ch_reg;
            SEG_PFX:   emit_ch = ((pfx_len_reg == 2'd2) && (cnt_reg == CNT_W'(1)))
                                 ? digit_char(6'(PFX_X_IDX), upper_reg) : CH_ZERO;
            SEG_FILL:  emit_ch = zp_reg ? CH_ZERO : CH_SPACE;
            SEG_PZERO: emit_ch = CH_ZERO;
            SEG_DIGIT: emit_ch = digit_char(rd_data_reg, upper_reg);
            default:   emit_ch = CH_SPACE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= emit_ch;
            last_reg     <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

    always_comb
    begin
        st.radix_ok = (radix >= 6'(RADIX_MIN)) && (radix <= 6'(RADIX_MAX));
        st.div_last = div_last;
        st.quo_zero = (div_q == '0);
        for (int s = 0; s < SEG_NUM; s++)
        begin
            st.seg_nz[s] = (seg_len_reg[s] != '0);
        end
        st.cnt_one  = (cnt_reg == CNT_W'(1));
        st.run_cap  = (run_reg == CNT_W'(MAX_RUN - 1));
        st.out_free = !out_valid_reg || !out_stall;
    end

endmodule

// File: rtl/core/integer_to_ascii_formatter_unit.sv
// Flow: the 8-bit-per-cycle radix divider generates the digits one divide at a time,
// then the ST_PREP and ST_SEL setup states run, then one character per cycle unless out_stall holds.
// The block takes no new transaction while an item is in progress; the next transaction
// is taken the cycle after the last character.
// Reset (rst_n, async, active low) clears control and the output valid; the digit
// store is not cleared.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS = itaf_pkg::DEF_VALUE_BITS,
    parameter int MAX_RUN    = itaf_pkg::DEF_MAX_RUN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [5:0]            radix,
    input  logic [6:0]            total_width,
    input  logic [5:0]            min_digits,
    input  logic [6:0]            format_flags,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_char,
    output logic                  last_char
);
    import itaf_pkg::*;

    `include "integer_to_ascii_formatter_unit_defines.svh"

    itaf_cmd_t  cmd;
    itaf_stat_t st;

    itaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    itaf_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RUN    (MAX_RUN)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .radix        (radix),
        .total_width  (total_width),
        .min_digits   (min_digits),
        .format_flags (format_flags),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last_char    (last_char)
    );

    `ITAF_ASSERT_NOW(a_emit_free, clk, rst_n, cmd.emit, st.out_free, "emit into a held output register")
    `ITAF_ASSERT_NEXT(a_busy_after_load, clk, rst_n, in_valid && !in_stall && st.radix_ok, in_stall, "not busy after a valid transaction")
    `ITAF_ASSERT_NEXT(a_idle_after_last, clk, rst_n, cmd.emit && cmd.last, !in_stall, "not idle after the last character")
    `ITAF_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid, "emitted character not presented")

endmodule

// File: sim/tb_integer_to_ascii_formatter_unit.sv
// Testbench for integer_to_ascii_formatter_unit: printf-style integer formatting checked
// character by character against an in-bench formatter model. Depends on itaf_pkg.
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter_unit;
    import itaf_pkg::*;

    localparam int NUM_BITS    = DEF_VALUE_BITS;
    localparam int RUN_LIMIT   = DEF_MAX_RUN;
    localparam int PREC_LIMIT  = DEF_MAX_RUN - 3;
    localparam int WATCHDOG    = 4000;
    localparam int SETTLE      = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_exp_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [NUM_BITS-1:0] value = '0;
    logic [5:0]          radix = 6'(RADIX_MIN);
    logic [6:0]          total_width = '0;
    logic [5:0]          min_digits = '0;
    logic [6:0]          format_flags = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [7:0]          out_char;
    logic                last_char;

    char_exp_t expected_chars[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    bit        idling_on = 1'b1;

    integer_to_ascii_formatter_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .radix        (radix),
        .total_width  (total_width),
        .min_digits   (min_digits),
        .format_flags (format_flags),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last_char    (last_char)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] ascii_digit(input int d, input logic upper);
        if (d < 10)
        begin
            return CH_ZERO + 8'(d);
        end
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
    endfunction

    // Build the formatted text of one number and queue it as expected characters.
    function automatic void format_number(input logic [NUM_BITS-1:0] num,
                                          input logic [5:0] base,
                                          input logic [6:0] fw,
                                          input logic [5:0] md,
                                          input logic [6:0] fl);
        logic [NUM_BITS-1:0] mag;
        int                  pad;
        int                  prec;
        int                  ndig;
        int                  i;
        int                  digits[NUM_BITS];
        logic [7:0]          sign_ch;
        logic                has_sign;
        logic                left;
        logic                zpad;
        logic                upper;
        logic                pfx;
        logic [7:0]          fill_ch;
        logic [7:0]          text[$];
        char_exp_t           e;

        mag = num;
        pad = int'(fw);
        if (pad > RUN_LIMIT)
            pad = RUN_LIMIT;
        prec = int'(md);
        if (prec > PREC_LIMIT)
            prec = PREC_LIMIT;
        left = fl[FLG_LEFT];
        zpad = fl[FLG_ZEROPAD] && !left;
        upper = fl[FLG_UPPER];
        pfx = fl[FLG_PREFIX];
        fill_ch = zpad ? CH_ZERO : CH_SPACE;

        has_sign = 1'b0;
        sign_ch = CH_SPACE;
        if (fl[FLG_SIGNED])
        begin
            if (mag[NUM_BITS-1])
            begin
                has_sign = 1'b1;
                sign_ch = CH_MINUS;
                mag = -mag;
            end
            else if (fl[FLG_PLUS])
            begin
                has_sign = 1'b1;
                sign_ch = CH_PLUS;
            end
            else if (fl[FLG_SPACE])
            begin
                has_sign = 1'b1;
                sign_ch = CH_SPACE;
            end
        end
        if (has_sign)
            pad--;
        if (pfx && base == 6'(RADIX_HEX))
            pad -= 2;
        else if (pfx && base == 6'(RADIX_OCT))
            pad -= 1;

        ndig = 0;
        do
        begin
            digits[ndig] = int'(mag % base);
            ndig++;
            mag = mag / base;
        end
        while (mag != 0 && ndig < NUM_BITS);

        if (ndig > prec)
            prec = ndig;
        pad -= prec;

        if (!zpad && !left)
        begin
            for (i = 0; i < pad; i++)
                text.push_back(CH_SPACE);
            if (pad > 0)
                pad = 0;
        end
        if (has_sign)
            text.push_back(sign_ch);
        if (pfx && (base == 6'(RADIX_OCT) || base == 6'(RADIX_HEX)))
            text.push_back(CH_ZERO);
        if (pfx && base == 6'(RADIX_HEX))
            text.push_back(ascii_digit(PFX_X_IDX, upper));
        if (!left)
        begin
            for (i = 0; i < pad; i++)
                text.push_back(fill_ch);
            if (pad > 0)
                pad = 0;
        end
        for (i = 0; i < prec - ndig; i++)
            text.push_back(CH_ZERO);
        for (i = ndig - 1; i >= 0; i--)
            text.push_back(ascii_digit(digits[i], upper));
        for (i = 0; i < pad; i++)
            text.push_back(CH_SPACE);

        // Truncate to the longest run the block emits.
        while (text.size() > RUN_LIMIT)
            void'(text.pop_back());
        for (i = 0; i < text.size(); i++)
        begin
            e.ch = text[i];
            e.last = (i == text.size() - 1);
            expected_chars.push_back(e);
        end
    endfunction

    // Output side: check each accepted character, then pick the next stall value.
    always @(posedge clk)
    begin
        char_exp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected char: out_char=%h last_char=%b", out_char, last_char);
            end
            else
            begin
                e = expected_chars.pop_front();
                if (out_char !== e.ch || last_char !== e.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("char mismatch: expected %h/%b, got %h/%b",
                                 e.ch, e.last, out_char, last_char);
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Drive one number and hold it until the block takes it.
    task automatic send_number(input logic [NUM_BITS-1:0] num, input logic [5:0] base,
                               input logic [6:0] fw, input logic [5:0] md,
                               input logic [6:0] fl);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= num;
        radix <= base;
        total_width <= fw;
        min_digits <= md;
        format_flags <= fl;
        do
            @(posedge clk);
        while (in_stall);
        format_number(num, base, fw, md, fl);
    endtask

    function automatic logic [NUM_BITS-1:0] pick_number();
        case ($urandom_range(0, 5))
            0: return NUM_BITS'($urandom_range(0, 40));
            1: return NUM_BITS'($urandom);
            2: return {1'b1, {(NUM_BITS-1){1'b0}}} + NUM_BITS'($urandom_range(0, 20));
            3: return {NUM_BITS{1'b1}} - NUM_BITS'($urandom_range(0, 20));
            4: return NUM_BITS'(1) << $urandom_range(0, NUM_BITS - 1);
            default: return NUM_BITS'($urandom) >> $urandom_range(0, NUM_BITS - 1);
        endcase
    endfunction

    function automatic logic [5:0] pick_radix();
        case ($urandom_range(0, 7))
            0: return 6'(RADIX_MIN);
            1: return 6'(RADIX_OCT);
            2: return 6'd10;
            3: return 6'(RADIX_HEX);
            4: return 6'(RADIX_MAX);
            default: return 6'($urandom_range(RADIX_MIN, RADIX_MAX));
        endcase
    endfunction

    task automatic send_random_number();
        logic [6:0] fw;
        logic [5:0] md;
        fw = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(25, RUN_LIMIT))
                                         : 7'($urandom_range(0, 24));
        md = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(13, PREC_LIMIT))
                                         : 6'($urandom_range(0, 12));
        send_number(pick_number(), pick_radix(), fw, md, 7'($urandom_range(0, 127)));
    endtask

    // Extremes of each field, every flag and each formatting corner.
    task automatic test_directed_cases();
        logic [6:0] f_zp;
        logic [6:0] f_sg;
        logic [6:0] f_pl;
        logic [6:0] f_sp;
        logic [6:0] f_lf;
        logic [6:0] f_px;
        logic [6:0] f_up;
        f_zp = 7'(1) << FLG_ZEROPAD;
        f_sg = 7'(1) << FLG_SIGNED;
        f_pl = 7'(1) << FLG_PLUS;
        f_sp = 7'(1) << FLG_SPACE;
        f_lf = 7'(1) << FLG_LEFT;
        f_px = 7'(1) << FLG_PREFIX;
        f_up = 7'(1) << FLG_UPPER;
        send_number('0, 6'd10, 7'd0, 6'd0, 7'd0);
        send_number('1, 6'd10, 7'd0, 6'd0, 7'd0);
        send_number({1'b1, {(NUM_BITS-1){1'b0}}}, 6'd10, 7'd0, 6'd0, f_sg);
        send_number('1, 6'd10, 7'd6, 6'd0, f_sg | f_zp);
        send_number(32'd42, 6'd10, 7'd8, 6'd0, f_sg | f_pl);
        send_number(32'd42, 6'd10, 7'd8, 6'd0, f_sg | f_sp);
        send_number(32'd42, 6'd10, 7'd8, 6'd0, f_sg | f_pl | f_sp | f_zp);
        send_number(32'd42, 6'd10, 7'd8, 6'd0, f_lf | f_sg | f_pl);
        send_number(32'd42, 6'd10, 7'd8, 6'd0, f_lf | f_zp);
        send_number(32'hDEADBEEF, 6'(RADIX_HEX), 7'd12, 6'd0, f_px | f_zp);
        send_number(32'hDEADBEEF, 6'(RADIX_HEX), 7'd12, 6'd0, f_px | f_up);
        send_number(32'o777, 6'(RADIX_OCT), 7'd6, 6'd0, f_px);
        send_number(32'd123, 6'd10, 7'd6, 6'd0, f_px);
        send_number('0, 6'(RADIX_HEX), 7'd0, 6'd0, f_px);
        send_number('0, 6'(RADIX_OCT), 7'd0, 6'd0, f_px);
        send_number('1, 6'(RADIX_MIN), 7'd0, 6'd0, 7'd0);
        send_number('1, 6'(RADIX_MAX), 7'd0, 6'd0, 7'd0);
        send_number('1, 6'(RADIX_MAX), 7'd0, 6'd0, f_up);
        send_number('1, 6'(RADIX_HEX), 7'(RUN_LIMIT), 6'(PREC_LIMIT),
                    f_sg | f_pl | f_px | f_up);
        send_number(32'd7, 6'd10, 7'(RUN_LIMIT), 6'd0, f_lf);
        send_number('0, 6'd10, 7'd0, 6'(PREC_LIMIT), 7'd0);
        send_number(32'd5, 6'd10, 7'd10, 6'd4, 7'd0);
        send_number(32'd5, 6'd10, 7'd10, 6'd4, f_zp);
        send_number(32'h8000_0001, 6'(RADIX_HEX), 7'd20, 6'd10, 7'h7F);
        send_number('0, 6'd10, 7'(RUN_LIMIT), 6'd0, f_zp | f_sg | f_sp);
    endtask

    // Random numbers, with stretches where neither side idles.
    task automatic test_random_numbers();
        for (int k = 0; k < 135; k++)
        begin
            idling_on = ((k / 30) % 3) != 2;
            send_random_number();
        end
        idling_on = 1'b1;
    endtask

    // Hold the sender until every character has drained, then restart.
    task automatic test_drain_pause();
        for (int r = 0; r < 2; r++)
        begin
            repeat (5) send_random_number();
            in_valid <= 1'b0;
            while (expected_chars.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        repeat (40) send_random_number();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_numbers();
        test_drain_pause();
        test_back_to_back();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
